// File: hw/rtl/msfc_pkg.sv
// Shared types, constants and the CRC-16/ARC byte update for the motor status frame checker.
package msfc_pkg;

  localparam int MOTOR_RECORDS_DEF = 12;
  localparam int REC_BYTES = 5;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  localparam logic CFG_CMD = 1'b0;
  localparam logic CFG_LEN = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_HDR = 2'd1,
    STATUS_CRC = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic out_load;
  } msfc_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic slot_free;
    logic emit_last;
  } msfc_sts_t;

  function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/msfc_ctrl.sv
// Controller: byte intake and per-record emission sequencing.
module msfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msfc_pkg::msfc_sts_t sts_i,
  output msfc_pkg::msfc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_RX,
    ST_RD,
    ST_LD
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;

  always_comb begin
    cmd_o.accept   = in_valid_i && rdy_q;
    cmd_o.out_load = (state_q == ST_LD) && sts_i.slot_free;
  end

  always_comb begin
    state_d = state_q;
    rdy_d   = rdy_q;
    unique case (state_q)
      ST_RX: begin
        if (cmd_o.accept && sts_i.frame_end) begin
          state_d = ST_RD;
          rdy_d   = 1'b0;
        end
      end
      ST_RD: begin
        state_d = ST_LD;
      end
      ST_LD: begin
        if (cmd_o.out_load) begin
          if (sts_i.emit_last) begin
            state_d = ST_RX;
            rdy_d   = 1'b1;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_RX;
        rdy_d   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RX;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
    end
  end

  assign in_ready_o = rdy_q;

`ifndef ASSERT_OFF
  a_rdy_only_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> (state_q == ST_RX))
    else $error("input ready outside intake state");
  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD) |-> ($past(state_q) == ST_RD || $past(state_q) == ST_LD))
    else $error("output load without preceding store read");
  a_end_leaves_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.frame_end) |=> (state_q == ST_RD && !rdy_q))
    else $error("frame end did not start emission");
`endif

endmodule

// File: hw/rtl/msfc_dp.sv
// Datapath: position count, CRC, header check, record store and output register.
module msfc_dp #(
  parameter int MOTOR_RECORDS = msfc_pkg::MOTOR_RECORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                first_byte_i,
  input  msfc_pkg::msfc_cmd_t cmd_i,
  output msfc_pkg::msfc_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [3:0]          motor_index_o,
  output logic [7:0]          rec_id_o,
  output logic signed [15:0]  position_o,
  output logic signed [15:0]  current_o,
  output logic                last_o
);

  localparam int FRAME_BYTES = 4 + msfc_pkg::REC_BYTES * MOTOR_RECORDS;
  localparam int PW = $clog2(FRAME_BYTES + 1);
  localparam int IW = (MOTOR_RECORDS > 1) ? $clog2(MOTOR_RECORDS) : 1;
  localparam logic [2:0] OFF_ID     = 3'd0;
  localparam logic [2:0] OFF_POS_HI = 3'd1;
  localparam logic [2:0] OFF_POS_LO = 3'd2;
  localparam logic [2:0] OFF_CUR_HI = 3'd3;
  localparam logic [2:0] OFF_CUR_LO = 3'd4;

  logic [7:0]        exp_cmd_q, exp_len_q;
  logic [PW-1:0]     bpos_q;
  logic [15:0]       crc_q;
  logic              hdr_q;
  logic [2:0]        off_q;
  logic [IW-1:0]     rec_q;
  logic [7:0]        crc_lo_q, hi_q, id_q;
  logic [15:0]       posv_q;
  logic [39:0]       rec_mem [MOTOR_RECORDS];
  logic [39:0]       rd_q;
  logic [IW-1:0]     emit_idx_q;
  msfc_pkg::status_e err_q;
  logic              out_valid_q;
  msfc_pkg::status_e status_q;
  logic [3:0]        midx_q;
  logic [7:0]        mid_q;
  logic [15:0]       mpos_q, mcur_q;
  logic              last_q;

  logic [PW-1:0]     p;
  logic              active, body, crc_span, wr_en;
  logic [15:0]       crc_base;
  logic [15:0]       got_crc;
  msfc_pkg::status_e frame_sts;
  logic [31:0]       idx_ext;

  always_comb begin
    p         = first_byte_i ? '0 : bpos_q;
    active    = p < PW'(FRAME_BYTES);
    crc_span  = p < PW'(FRAME_BYTES - 2);
    body      = (p >= PW'(2)) && crc_span;
    wr_en     = body && (off_q == OFF_CUR_LO);
    crc_base  = first_byte_i ? 16'h0000 : crc_q;
    got_crc   = {rx_byte_i, crc_lo_q};
    if (!hdr_q) begin
      frame_sts = msfc_pkg::STATUS_HDR;
    end else if (got_crc != crc_q) begin
      frame_sts = msfc_pkg::STATUS_CRC;
    end else begin
      frame_sts = msfc_pkg::STATUS_OK;
    end
    idx_ext   = 32'(emit_idx_q);
  end

  always_comb begin
    sts_o.frame_end = (p == PW'(FRAME_BYTES - 1));
    sts_o.slot_free = !out_valid_q || out_ready_i;
    sts_o.emit_last = (err_q != msfc_pkg::STATUS_OK) ||
                      (emit_idx_q == IW'(MOTOR_RECORDS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cmd_q <= '0;
      exp_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msfc_pkg::CFG_CMD: exp_cmd_q <= cfg_wdata_i;
        msfc_pkg::CFG_LEN: exp_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q     <= '0;
      crc_q      <= '0;
      hdr_q      <= 1'b0;
      off_q      <= OFF_ID;
      rec_q      <= '0;
      err_q      <= msfc_pkg::STATUS_OK;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.accept && active) begin
        bpos_q <= p + PW'(1);
        if (crc_span) begin
          crc_q <= msfc_pkg::crc16_arc_byte(crc_base, rx_byte_i);
        end
        if (p == PW'(0)) begin
          hdr_q <= (rx_byte_i == exp_cmd_q);
        end else if (p == PW'(1)) begin
          hdr_q <= hdr_q && (rx_byte_i == exp_len_q);
        end
        if (body) begin
          if (off_q == OFF_CUR_LO) begin
            off_q <= OFF_ID;
            rec_q <= rec_q + IW'(1);
          end else begin
            off_q <= off_q + 3'd1;
          end
        end else begin
          off_q <= OFF_ID;
          rec_q <= '0;
        end
        if (sts_o.frame_end) begin
          err_q      <= frame_sts;
          emit_idx_q <= '0;
        end
      end else if (cmd_i.out_load) begin
        emit_idx_q <= emit_idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && active) begin
      if (body) begin
        case (off_q)
          OFF_ID:                 id_q   <= rx_byte_i;
          OFF_POS_HI, OFF_CUR_HI: hi_q   <= rx_byte_i;
          OFF_POS_LO:             posv_q <= {hi_q, rx_byte_i};
          default: ;
        endcase
      end
      if (p == PW'(FRAME_BYTES - 2)) begin
        crc_lo_q <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && active && wr_en) begin
      rec_mem[rec_q] <= {id_q, posv_q, hi_q, rx_byte_i};
    end
    rd_q <= rec_mem[emit_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= err_q;
      last_q   <= sts_o.emit_last;
      if (err_q != msfc_pkg::STATUS_OK) begin
        midx_q <= '0;
        mid_q  <= '0;
        mpos_q <= '0;
        mcur_q <= '0;
      end else begin
        midx_q <= idx_ext[3:0];
        mid_q  <= rd_q[39:32];
        mpos_q <= rd_q[31:16];
        mcur_q <= rd_q[15:0];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign motor_index_o = midx_q;
  assign rec_id_o      = mid_q;
  assign position_o    = mpos_q;
  assign current_o     = mcur_q;
  assign last_o        = last_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != msfc_pkg::STATUS_OK) |-> last_q)
    else $error("error result not marked last");
  a_rec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && active && wr_en) |-> (32'(rec_q) < MOTOR_RECORDS))
    else $error("record write beyond store");
  a_end_clears_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && sts_o.frame_end) |=> (emit_idx_q == '0))
    else $error("emission index not restarted at frame end");
`endif

endmodule

// File: hw/rtl/motor_status_frame_checker_top.sv
// Motor status frame checker top level: CRC-16/ARC checked deframer of motor records.
// Takes one frame byte per cycle while receiving. When the final CRC byte is taken,
// input stalls and the results leave through the output register: an error frame gives
// one result after the store-read and load states; a good frame gives one record per pass
// through the store-read and load states (the record store's registered read), each load
// waiting on output back-pressure, and bytes are taken again only after the last record.
module motor_status_frame_checker_top #(
  parameter int MOTOR_RECORDS = msfc_pkg::MOTOR_RECORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               first_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [3:0]         motor_index_o,
  output logic [7:0]         rec_id_o,
  output logic signed [15:0] position_o,
  output logic signed [15:0] current_o,
  output logic               last_o
);

  msfc_pkg::msfc_cmd_t cmd;
  msfc_pkg::msfc_sts_t sts;

  msfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msfc_dp #(
    .MOTOR_RECORDS (MOTOR_RECORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (rx_byte_i),
    .first_byte_i  (first_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .motor_index_o (motor_index_o),
    .rec_id_o      (rec_id_o),
    .position_o    (position_o),
    .current_o     (current_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/sv/tb_motor_status_frame_checker_top.sv
// Self-checking testbench for the motor status frame checker: directed and random frames.
`timescale 1ns / 1ps

module tb_motor_status_frame_checker_top;

  localparam int NREC = msfc_pkg::MOTOR_RECORDS_DEF;
  localparam int REC_SPAN = NREC * msfc_pkg::REC_BYTES;
  localparam int FRAME_LEN = 2 + REC_SPAN + 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int WD_LIMIT = 2000;

  typedef enum logic [2:0] {
    FRM_GOOD, FRM_BAD_CMD, FRM_BAD_LEN, FRM_BAD_CRC, FRM_BAD_BOTH, FRM_CUT, FRM_TRAIL
  } frame_e;

  typedef enum logic [2:0] {
    FILL_ZERO, FILL_ONES, FILL_MAX, FILL_MIN, FILL_RAND
  } fill_e;

  typedef struct packed {
    logic              set_cfg;
    logic [7:0]        cmd;
    logic [7:0]        len;
    frame_e            kind;
    logic              flag;
    fill_e             fill;
    logic              typed;
    msfc_pkg::status_e st;
  } dir_row_t;

  typedef struct {
    msfc_pkg::status_e  st;
    logic [3:0]         idx;
    logic [7:0]         id;
    logic signed [15:0] pos;
    logic signed [15:0] cur;
    logic               last;
  } motor_result_t;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] cur;
  } motor_rec_t;

  localparam dir_row_t DIR_ROWS [3] = '{
    '{1'b0, 8'h00, 8'h00, FRM_GOOD,    1'b0, FILL_MAX,  1'b0, msfc_pkg::STATUS_OK},
    '{1'b0, 8'h00, 8'h00, FRM_CUT,     1'b1, FILL_RAND, 1'b0, msfc_pkg::STATUS_OK},
    '{1'b1, 8'hA5, 8'h3C, FRM_BAD_CMD, 1'b1, FILL_RAND, 1'b1, msfc_pkg::STATUS_HDR}
  };

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = msfc_pkg::CFG_CMD;
  logic [7:0]         cfg_wdata = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               first_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [3:0]         motor_index;
  logic [7:0]         rec_id;
  logic signed [15:0] position;
  logic signed [15:0] current;
  logic               last;

  logic [7:0]    cmd_reg = 8'h00;
  logic [7:0]    len_reg = 8'h00;
  int            pos_cnt = 0;
  logic [15:0]   crc_acc = 16'h0000;
  logic          hdr_ok = 1'b0;
  logic [7:0]    hi_byte = 8'h00;
  logic [7:0]    crc_lo = 8'h00;
  motor_rec_t    motor_recs [NREC];

  motor_result_t     due_records [$];
  motor_result_t     new_records [$];
  msfc_pkg::status_e typed_status_q [$];

  int n_errors = 0;
  int n_bytes = 0;
  int gap_pct = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  motor_status_frame_checker_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .first_byte_i  (first_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .motor_index_o (motor_index),
    .rec_id_o      (rec_id),
    .position_o    (position),
    .current_o     (current),
    .last_o        (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] arc_crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic f);
    int rel;
    logic [15:0] rx_crc;
    if (f) begin
      pos_cnt = 0;
      crc_acc = 16'h0000;
      hdr_ok = 1'b0;
    end
    if (pos_cnt >= FRAME_LEN) return;
    rel = pos_cnt - 2;
    pos_cnt++;
    if (rel < REC_SPAN) crc_acc = arc_crc_next(crc_acc, b);
    if (rel == -2) begin
      hdr_ok = (b == cmd_reg);
    end else if (rel == -1) begin
      hdr_ok = hdr_ok && (b == len_reg);
    end else if (rel < REC_SPAN) begin
      case (rel % msfc_pkg::REC_BYTES)
        0: motor_recs[rel / msfc_pkg::REC_BYTES].id = b;
        1, 3: hi_byte = b;
        2: motor_recs[rel / msfc_pkg::REC_BYTES].pos = {hi_byte, b};
        default: motor_recs[rel / msfc_pkg::REC_BYTES].cur = {hi_byte, b};
      endcase
    end else if (rel == REC_SPAN) begin
      crc_lo = b;
    end else begin
      rx_crc = {b, crc_lo};
      if (!hdr_ok) begin
        new_records.insert(new_records.size(), motor_result_t'{msfc_pkg::STATUS_HDR,
                           4'd0, 8'd0, 16'sd0, 16'sd0, 1'b1});
      end else if (rx_crc != crc_acc) begin
        new_records.insert(new_records.size(), motor_result_t'{msfc_pkg::STATUS_CRC,
                           4'd0, 8'd0, 16'sd0, 16'sd0, 1'b1});
      end else begin
        for (int k = 0; k < NREC; k++) begin
          new_records.insert(new_records.size(), motor_result_t'{msfc_pkg::STATUS_OK,
                             4'(k), motor_recs[k].id, motor_recs[k].pos,
                             motor_recs[k].cur, k == NREC - 1});
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      n_errors++;
    end
  endfunction

  function automatic void build_frame(input logic [7:0] c, input logic [7:0] l,
                                      input fill_e fill, input bit crc_bad,
                                      output logic [7:0] fr [FRAME_LEN]);
    logic [15:0] crc;
    int off;
    fr[0] = c;
    fr[1] = l;
    for (int k = 2; k < FRAME_LEN - 2; k++) begin
      off = (k - 2) % msfc_pkg::REC_BYTES;
      case (fill)
        FILL_ZERO: fr[k] = 8'h00;
        FILL_ONES: fr[k] = 8'hFF;
        FILL_MAX:  fr[k] = (off == 1 || off == 3) ? 8'h7F : 8'hFF;
        FILL_MIN:  fr[k] = (off == 1 || off == 3) ? 8'h80 : 8'h00;
        default:   fr[k] = 8'($urandom);
      endcase
    end
    crc = 16'h0000;
    for (int k = 0; k < FRAME_LEN - 2; k++) crc = arc_crc_next(crc, fr[k]);
    if (crc_bad) crc ^= 16'($urandom_range(1, 16'hFFFF));
    fr[FRAME_LEN-2] = crc[7:0];
    fr[FRAME_LEN-1] = crc[15:8];
  endfunction

  // drop valid for a burst now and then, then hold the byte until taken
  task automatic put_byte(input logic [7:0] b, input logic f);
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    first_byte <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] c, input logic [7:0] l);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= msfc_pkg::CFG_CMD;
    cfg_wdata <= c;
    @(posedge clk);
    cmd_reg = c;
    cfg_idx   <= msfc_pkg::CFG_LEN;
    cfg_wdata <= l;
    @(posedge clk);
    len_reg = l;
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input frame_e kind, input bit flag, input fill_e fill,
                            input bit typed = 1'b0,
                            input msfc_pkg::status_e typed_st = msfc_pkg::STATUS_OK);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] c;
    logic [7:0] l;
    int n;
    c = cmd_reg;
    l = len_reg;
    if (kind == FRM_BAD_CMD || kind == FRM_BAD_BOTH) c ^= 8'($urandom_range(1, 255));
    if (kind == FRM_BAD_LEN) l ^= 8'($urandom_range(1, 255));
    build_frame(c, l, fill, kind == FRM_BAD_CRC || kind == FRM_BAD_BOTH, fr);
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
    n = (kind == FRM_CUT) ? $urandom_range(1, 2 + 2 * msfc_pkg::REC_BYTES) : FRAME_LEN;
    for (int i = 0; i < n; i++) begin
      if (typed && i == n - 1) typed_status_q.insert(typed_status_q.size(), typed_st);
      put_byte(fr[i], flag && i == 0);
    end
    if (kind == FRM_TRAIL) begin
      repeat ($urandom_range(1, 5)) put_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    motor_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_bytes++;
        absorb_byte(rx_byte, first_byte);
        if (new_records.size() > 0 && typed_status_q.size() > 0) begin
          due_records.insert(due_records.size(), motor_result_t'{typed_status_q.pop_front(),
                             4'd0, 8'd0, 16'sd0, 16'sd0, 1'b1});
          new_records.delete();
        end else begin
          while (new_records.size() > 0) begin
            due_records.insert(due_records.size(), new_records.pop_front());
          end
        end
      end
      if (out_valid && out_ready) begin
        if (due_records.size() == 0) begin
          $error("unexpected result: status %0d, motor_index %0d", status, motor_index);
          n_errors++;
        end else begin
          want = due_records.pop_front();
          check_field("status", want.st, status);
          check_field("motor_index", want.idx, motor_index);
          check_field("rec_id", want.id, rec_id);
          check_field("position", want.pos, position);
          check_field("current", want.cur, current);
          check_field("last", want.last, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WD_LIMIT) begin
      $display("tb_motor_status_frame_checker_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int b0;
    int roll;
    bit flag;
    foreach (motor_recs[i]) motor_recs[i] = '{8'h00, 16'h0000, 16'h0000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].set_cfg) write_config(DIR_ROWS[i].cmd, DIR_ROWS[i].len);
      send_frame(DIR_ROWS[i].kind, DIR_ROWS[i].flag, DIR_ROWS[i].fill,
                 DIR_ROWS[i].typed, DIR_ROWS[i].st);
    end

    b0 = n_bytes;
    while ((n_bytes - b0) < 24) begin
      if ($urandom_range(0, 7) == 0) begin
        write_config(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end else if ($urandom_range(0, 5) == 0) begin
        settle();
      end
      roll = $urandom_range(0, 99);
      flag = $urandom_range(0, 9) != 0;
      if (roll < 40) send_frame(FRM_GOOD, flag, FILL_RAND);
      else if (roll < 50) send_frame(FRM_BAD_CRC, flag, FILL_RAND);
      else if (roll < 56) send_frame(FRM_BAD_CMD, flag, FILL_RAND);
      else if (roll < 60) send_frame(FRM_BAD_LEN, flag, FILL_RAND);
      else if (roll < 63) send_frame(FRM_BAD_BOTH, flag, FILL_RAND);
      else if (roll < 70) send_frame(FRM_TRAIL, flag, FILL_RAND);
      else if (roll < 85) send_frame(FRM_CUT, flag, FILL_RAND);
      else begin
        repeat ($urandom_range(1, 10)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    quiet = 1'b1;
    send_frame(FRM_GOOD, 1'b1, FILL_MIN);
    settle();

    if (n_errors == 0) begin
      $display("tb_motor_status_frame_checker_top: PASS");
    end else begin
      $display("tb_motor_status_frame_checker_top: FAIL");
    end
    $finish;
  end

endmodule
